// ----- rtl/core/soft_timer_bank_macros.svh -----
// Assertion macros for the soft timer bank.
// Shared by every file that asserts; expects a clock named clk and a reset named rst.
`ifndef SOFT_TIMER_BANK_MACROS_SVH
`define SOFT_TIMER_BANK_MACROS_SVH

// Check a property outside reset.
`define STB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every clock edge, reset included.
`define STB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/stb_pkg.sv -----
// Package for the soft timer bank: sizes, command codes and the queued work item.
// No dependencies; used by every module of the block.
`default_nettype none

package stb_pkg;

  // Bank size and derived widths
  localparam int TIMERS = 8;
  localparam int ID_W   = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int CNT_W  = $clog2(TIMERS + 1);

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Raw command codes on the input port
  localparam logic [2:0] CMD_TICK       = 3'd0;
  localparam logic [2:0] CMD_START_ONCE = 3'd1;
  localparam logic [2:0] CMD_START_AUTO = 3'd2;
  localparam logic [2:0] CMD_STOP       = 3'd3;
  localparam logic [2:0] CMD_CHECK      = 3'd4;
  localparam logic [2:0] CMD_DELAY      = 3'd5;

  // Classified operation carried to the back end
  typedef enum logic [2:0] {
    OP_TICK,
    OP_START,
    OP_STOP,
    OP_CHECK,
    OP_DELAY,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t             op;
    logic            auto_sel;
    logic            bad;
    logic [ID_W-1:0] id;
    logic [31:0]     period;
  } work_t;

endpackage

`default_nettype wire

// ----- rtl/core/soft_timer_bank.sv -----
// A non-tick command is registered in the command queue and then in the result register, once the back is free.
// A tick holds the back end in its sweep, one timer a cycle through the one read port and the
// one write port of each timer memory. Other commands need no sweep.
// A two-entry command queue keeps accepting, until it is full, while the back end works or a result waits.
// Reset: synchronous; flags, counters and per-timer valid bits clear at once.
`default_nettype none

module soft_timer_bank (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         cmd,
  input  logic [7:0]         timer_id,
  input  logic [31:0]        period,
  output logic               empty,
  input  logic               pop,
  output logic               expired,
  output logic               bad_id,
  output logic               delay_done,
  output logic signed [31:0] run_time
);

  stb_pkg::work_t front_item;
  stb_pkg::work_t q_item;
  logic           q_avail;
  logic           q_pop;
  logic           res_valid;
  logic [31:0]    tick_total;

  // Classify the incoming command
  stb_front u_front (
    .cmd      (cmd),
    .timer_id (timer_id),
    .period   (period),
    .item     (front_item)
  );

  // Decouple front and back
  stb_cmdq u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr      (push),
    .wr_item (front_item),
    .full    (full),
    .avail   (q_avail),
    .rd_item (q_item),
    .rd      (q_pop)
  );

  // Execute commands and hold the result
  stb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_avail    (q_avail),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .res_valid  (res_valid),
    .res_pop    (pop),
    .res_exp    (expired),
    .res_bad    (bad_id),
    .delay_flag (delay_done),
    .tick_total (tick_total)
  );

  assign empty    = !res_valid;
  assign run_time = signed'(tick_total);

endmodule

`default_nettype wire

// ----- rtl/core/stb_front.sv -----
// Front end of the soft timer bank: decodes and classifies one command.
// Depends on stb_pkg.
`default_nettype none

module stb_front (
  input  logic [2:0]          cmd,
  input  logic [7:0]          timer_id,
  input  logic [31:0]         period,
  output stb_pkg::work_t      item
);

  logic timer_cmd;
  logic id_bad;

  // Flag timer commands that name an id beyond the bank
  assign timer_cmd = (cmd == stb_pkg::CMD_START_ONCE) || (cmd == stb_pkg::CMD_START_AUTO) ||
                     (cmd == stb_pkg::CMD_STOP) || (cmd == stb_pkg::CMD_CHECK);
  assign id_bad    = timer_cmd && (timer_id >= 8'(stb_pkg::TIMERS));

  // Map the raw code to an operation; bad ids and unused codes do nothing
  always_comb begin
    item.auto_sel = (cmd == stb_pkg::CMD_START_AUTO);
    item.bad      = id_bad;
    item.id       = timer_id[stb_pkg::ID_W-1:0];
    item.period   = period;
    if (id_bad) begin
      item.op = stb_pkg::OP_NONE;
    end else begin
      case (cmd)
        stb_pkg::CMD_TICK:       item.op = stb_pkg::OP_TICK;
        stb_pkg::CMD_START_ONCE: item.op = stb_pkg::OP_START;
        stb_pkg::CMD_START_AUTO: item.op = stb_pkg::OP_START;
        stb_pkg::CMD_STOP:       item.op = stb_pkg::OP_STOP;
        stb_pkg::CMD_CHECK:      item.op = stb_pkg::OP_CHECK;
        stb_pkg::CMD_DELAY:      item.op = stb_pkg::OP_DELAY;
        default:                 item.op = stb_pkg::OP_NONE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/stb_cmdq.sv -----
// Short command queue between the front and back ends of the soft timer bank.
// Depends on stb_pkg.
`default_nettype none

module stb_cmdq (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  stb_pkg::work_t wr_item,
  output logic           full,
  output logic           avail,
  output stb_pkg::work_t rd_item,
  input  logic           rd
);

  stb_pkg::work_t                entries [stb_pkg::QDEPTH];
  logic [stb_pkg::QPTR_W-1:0]    wr_ptr;
  logic [stb_pkg::QPTR_W-1:0]    rd_ptr;
  logic [stb_pkg::QCNT_W-1:0]    count;
  logic                          do_wr;
  logic                          do_rd;

  assign full    = (count == stb_pkg::QCNT_W'(stb_pkg::QDEPTH));
  assign avail   = (count != '0);
  assign rd_item = entries[rd_ptr];
  assign do_wr   = wr && !full;
  assign do_rd   = rd && avail;

  // Hold queued items
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_item;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == stb_pkg::QPTR_W'(stb_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == stb_pkg::QPTR_W'(stb_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/stb_back.sv -----
// Back end of the soft timer bank: executes commands, sweeps the timers on a tick
// and holds the result until it is taken. Depends on stb_pkg and the macro header.
`default_nettype none
`include "soft_timer_bank_macros.svh"

module stb_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_avail,
  input  stb_pkg::work_t       q_item,
  output logic                 q_pop,
  output logic                 res_valid,
  input  logic                 res_pop,
  output logic                 res_exp,
  output logic                 res_bad,
  output logic                 delay_flag,
  output logic [31:0]          tick_total
);

  typedef enum logic {S_IDLE, S_SWEEP} state_t;

  state_t                      state;
  logic [stb_pkg::CNT_W-1:0]   cnt;
  logic [stb_pkg::TIMERS-1:0]  valid;
  logic [stb_pkg::TIMERS-1:0]  exp_flag;
  logic [stb_pkg::TIMERS-1:0]  auto_mode;
  logic [31:0]                 delay_left;

  // Timer memories, read one entry a cycle during the sweep
  logic [31:0]                 rem_mem [stb_pkg::TIMERS];
  logic [31:0]                 rld_mem [stb_pkg::TIMERS];
  logic [31:0]                 rem_rd;
  logic [31:0]                 rld_rd;
  logic                        rd_val;

  logic                        take;
  logic                        proc;
  logic [stb_pkg::CNT_W-1:0]   cnt_prev;
  logic [stb_pkg::ID_W-1:0]    wr_idx;
  logic [stb_pkg::ID_W-1:0]    rd_addr;
  logic [31:0]                 cur;
  logic [31:0]                 dec;
  logic                        run_dec;
  logic                        hit;
  logic                        rem_we;
  logic                        rld_we;
  logic [stb_pkg::ID_W-1:0]    rem_wa;
  logic [31:0]                 rem_wd;

  // Decode the current step: take a command, or process one swept entry
  always_comb begin
    take     = (state == S_IDLE) && q_avail && (!res_valid || res_pop);
    proc     = (state == S_SWEEP) && (cnt != '0);
    cnt_prev = cnt - 1'b1;
    wr_idx   = cnt_prev[stb_pkg::ID_W-1:0];
    rd_addr  = (cnt < stb_pkg::CNT_W'(stb_pkg::TIMERS)) ? cnt[stb_pkg::ID_W-1:0] : '0;
    cur      = rd_val ? rem_rd : '0;
    dec      = cur - 32'd1;
    run_dec  = proc && (cur != '0);
    hit      = run_dec && (dec == '0);
    rld_we   = take && (q_item.op == stb_pkg::OP_START);
    rem_we   = rld_we || run_dec;
    rem_wa   = take ? q_item.id : wr_idx;
    if (take) begin
      rem_wd = q_item.period;
    end else if (hit && auto_mode[wr_idx]) begin
      rem_wd = rld_rd;
    end else begin
      rem_wd = dec;
    end
  end

  assign q_pop = take;

  // Write and read the timer memories
  always_ff @(posedge clk) begin
    if (rem_we) begin
      rem_mem[rem_wa] <= rem_wd;
    end
    if (rld_we) begin
      rld_mem[rem_wa] <= q_item.period;
    end
    rem_rd <= rem_mem[rd_addr];
    rld_rd <= rld_mem[rd_addr];
    rd_val <= valid[rd_addr];
  end

  // Hold state, per-timer flags, delay, tick count and the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      valid      <= '0;
      exp_flag   <= '0;
      auto_mode  <= '0;
      delay_left <= '0;
      delay_flag <= 1'b0;
      tick_total <= '0;
      res_valid  <= 1'b0;
      res_exp    <= 1'b0;
      res_bad    <= 1'b0;
    end else begin
      // Drop a transferred result unless a new command replaces it
      if (res_pop && res_valid && !take) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            res_exp   <= (q_item.op == stb_pkg::OP_CHECK) ? exp_flag[q_item.id] : 1'b0;
            res_bad   <= q_item.bad;
            res_valid <= (q_item.op != stb_pkg::OP_TICK);
            case (q_item.op)
              stb_pkg::OP_TICK: begin
                if (delay_left != '0) begin
                  delay_left <= delay_left - 32'd1;
                  if (delay_left == 32'd1) begin
                    delay_flag <= 1'b1;
                  end
                end
                tick_total <= tick_total + 32'd1;
                cnt        <= '0;
                state      <= S_SWEEP;
              end
              stb_pkg::OP_START: begin
                valid[q_item.id]     <= 1'b1;
                exp_flag[q_item.id]  <= 1'b0;
                auto_mode[q_item.id] <= q_item.auto_sel;
              end
              stb_pkg::OP_STOP: begin
                valid[q_item.id]     <= 1'b0;
                exp_flag[q_item.id]  <= 1'b0;
                auto_mode[q_item.id] <= 1'b0;
              end
              stb_pkg::OP_DELAY: begin
                if (q_item.period == '0) begin
                  delay_left <= '0;
                  delay_flag <= 1'b1;
                end else begin
                  delay_left <= (q_item.period == 32'd1) ? 32'd2 : q_item.period;
                  delay_flag <= 1'b0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SWEEP: begin
          if (hit) begin
            exp_flag[wr_idx] <= 1'b1;
          end
          if (cnt == stb_pkg::CNT_W'(stb_pkg::TIMERS)) begin
            state     <= S_IDLE;
            res_valid <= 1'b1;
            res_exp   <= 1'b0;
            res_bad   <= 1'b0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `STB_ASSERT(a_cnt_range, cnt <= stb_pkg::CNT_W'(stb_pkg::TIMERS), "sweep counter out of range")
  `STB_ASSERT(a_sweep_end, (state == S_SWEEP && cnt == stb_pkg::CNT_W'(stb_pkg::TIMERS)) |=> (state == S_IDLE && res_valid), "sweep did not finish with a result")
  `STB_ASSERT(a_no_take_waiting, (res_valid && !res_pop) |-> !q_pop, "command taken while a result waits")
  `STB_ASSERT(a_tick_count, (q_pop && q_item.op == stb_pkg::OP_TICK) |=> (tick_total == $past(tick_total) + 32'd1), "tick did not advance run time")

endmodule

`default_nettype wire
